// ===== rtl/ssg_pkg.sv =====
package ssg_pkg;

    // grid and number format
    localparam int DIM_BITS      = 10;
    localparam int FRAC_BITS     = 28;
    localparam int CORDIC_STAGES = 24;

    localparam int IDX_W   = 3 * DIM_BITS;
    localparam int COORD_W = 32;
    localparam int CFG_W   = 32;
    localparam int VAL_W   = 33;
    localparam int QUOT_W  = 32;

    // pipeline depths
    localparam int FRONT_LAT  = 3 * DIM_BITS + 2;
    localparam int LERP_LAT   = QUOT_W + 3;
    localparam int CORDIC_LAT = CORDIC_STAGES + 3;
    localparam int BACK_LAT   = LERP_LAT + CORDIC_LAT + 4;
    localparam int FIFO_DEPTH = 4;

    // Q30 angle constants
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint CORDIC_GAIN = 64'sd652032874;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16777898, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef enum logic [2:0] {
        REG_MESH_DIMS  = 3'd0,
        REG_MIN_THETA  = 3'd1,
        REG_MAX_THETA  = 3'd2,
        REG_MIN_PHI    = 3'd3,
        REG_MAX_PHI    = 3'd4,
        REG_MIN_RADIUS = 3'd5,
        REG_MAX_RADIUS = 3'd6
    } ssg_reg_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] n0;
        logic [DIM_BITS-1:0] n1;
        logic [DIM_BITS-1:0] n2;
        logic signed [31:0]  min_theta;
        logic signed [31:0]  max_theta;
        logic signed [31:0]  min_phi;
        logic signed [31:0]  max_phi;
        logic [30:0]         min_radius;
        logic [30:0]         max_radius;
    } ssg_cfg_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] i;
        logic [DIM_BITS-1:0] j;
        logic [DIM_BITS-1:0] k;
        logic                oor;
    } ssg_item_t;

endpackage

// ===== rtl/spherical_shell_grid_point.sv =====
// Spherical shell grid point generator.
// Input channel: in_valid / in_stall with point_index, the linear grid index
// (i fastest, k slowest). Output channel: out_valid / out_stall with x_coord,
// y_coord, z_coord (signed Q4.28) and out_of_range. Each item gives one result.
// Configuration: cfg_we, cfg_index, cfg_data write the grid sizes and the
// theta, phi and radius limits; write them only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. The item
// passes 32 registers in the index splitter (one quotient bit per divider
// stage), one in the queue and 66 in the back end (35 interpolation with one
// quotient bit per divider stage, 27 CORDIC, four in the multiply and saturate
// stages); the accepting edge loads the first of them.
// Reset clears all valid bits and the queue and loads the default grid
// (2 x 2 x 2). When the receiver stalls the back end holds its result; the
// front end keeps accepting until the four-entry queue between them fills,
// then in_stall rises. An index at or past the point count returns
// out_of_range with all three coordinates at positive full scale.
module spherical_shell_grid_point
    import ssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [IDX_W-1:0]          point_index,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] x_coord,
    output logic signed [COORD_W-1:0] y_coord,
    output logic signed [COORD_W-1:0] z_coord,
    output logic                      out_of_range,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int D = DIM_BITS;

    ssg_cfg_t  cfg_reg;
    ssg_item_t f_item;
    ssg_item_t q_item;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.n0         <= D'(2);
            cfg_reg.n1         <= D'(2);
            cfg_reg.n2         <= D'(2);
            cfg_reg.min_theta  <= 32'sd562209903;
            cfg_reg.max_theta  <= 32'sd281104951;
            cfg_reg.min_phi    <= 32'sd562209903;
            cfg_reg.max_phi    <= 32'sd281104951;
            cfg_reg.min_radius <= 31'd134217728;
            cfg_reg.max_radius <= 31'd268435456;
        end
        else if (cfg_we)
        begin
            case (ssg_reg_t'(cfg_index))
                REG_MESH_DIMS:
                begin
                    cfg_reg.n0 <= cfg_data[D-1:0];
                    cfg_reg.n1 <= cfg_data[2*D-1:D];
                    cfg_reg.n2 <= cfg_data[3*D-1:2*D];
                end
                REG_MIN_THETA:  cfg_reg.min_theta  <= cfg_data[31:0];
                REG_MAX_THETA:  cfg_reg.max_theta  <= cfg_data[31:0];
                REG_MIN_PHI:    cfg_reg.min_phi    <= cfg_data[31:0];
                REG_MAX_PHI:    cfg_reg.max_phi    <= cfg_data[31:0];
                REG_MIN_RADIUS: cfg_reg.min_radius <= cfg_data[30:0];
                REG_MAX_RADIUS: cfg_reg.max_radius <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    ssg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .point_index (point_index),
        .cfg         (cfg_reg),
        .fifo_full   (q_full),
        .in_stall    (in_stall),
        .push        (push),
        .item        (f_item)
    );

    ssg_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (f_item),
        .pop     (pop),
        .full    (q_full),
        .empty   (q_empty),
        .rd_item (q_item)
    );

    ssg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fifo_empty   (q_empty),
        .rd_item      (q_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .z_coord      (z_coord),
        .out_of_range (out_of_range)
    );

endmodule

// ===== rtl/ssg_front.sv =====
module ssg_front
    import ssg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [IDX_W-1:0] point_index,
    input  ssg_cfg_t         cfg,
    input  logic             fifo_full,
    output logic             in_stall,
    output logic             push,
    output ssg_item_t        item
);

    localparam int D  = DIM_BITS;
    localparam int W2 = 2 * DIM_BITS;
    localparam int W3 = 3 * DIM_BITS;

    logic [W3-1:0] idx_reg [0:W3];
    logic [W3-1:0] a_reg   [1:W2];
    logic [W2-1:0] b_reg   [1:D];
    logic [D-1:0]  i_reg   [1:D];
    logic          fv_reg  [0:W3+1];
    ssg_item_t     item_reg;
    logic [W2-1:0] p01_reg;
    logic [W3-1:0] count_reg;
    logic          fadv;

    // one restoring step: remainder on top, quotient bits fill from below
    function automatic logic [W3-1:0] step_a(input logic [W3-1:0] a, input logic [D-1:0] dv);
        logic [D:0] t;
        logic       ge;
        t  = a[W3-1:W2-1];
        ge = (t >= {1'b0, dv});
        return {ge ? D'(t - {1'b0, dv}) : t[D-1:0], a[W2-2:0], ge};
    endfunction

    function automatic logic [W2-1:0] step_b(input logic [W2-1:0] b, input logic [D-1:0] dv);
        logic [D:0] t;
        logic       ge;
        t  = b[W2-1:D-1];
        ge = (t >= {1'b0, dv});
        return {ge ? D'(t - {1'b0, dv}) : t[D-1:0], b[D-2+1-1:0], ge};
    endfunction

    // hold everything while the finished item cannot enter the queue
    assign fadv     = !(fv_reg[W3+1] && fifo_full);
    assign in_stall = !fadv;
    assign push     = fv_reg[W3+1] && !fifo_full;
    assign item     = item_reg;

    // point count from the grid sizes
    always_ff @(posedge clk)
    begin
        p01_reg   <= W2'(cfg.n0) * W2'(cfg.n1);
        count_reg <= W3'(p01_reg) * W3'(cfg.n2);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= W3 + 1; s++)
                fv_reg[s] <= 1'b0;
        end
        else if (fadv)
        begin
            fv_reg[0] <= in_valid;
            for (int s = 1; s <= W3 + 1; s++)
                fv_reg[s] <= fv_reg[s-1];
        end
    end

    // carry the index for the range check
    always_ff @(posedge clk)
    begin
        if (fadv)
        begin
            idx_reg[0] <= point_index;
            for (int s = 1; s <= W3; s++)
                idx_reg[s] <= idx_reg[s-1];
        end
    end

    // divide the index by the i size
    for (genvar s = 1; s <= W2; s++)
    begin : g_div_a
        always_ff @(posedge clk)
        begin
            if (fadv)
            begin
                if (s == 1)
                    a_reg[s] <= step_a(idx_reg[0], cfg.n0);
                else
                    a_reg[s] <= step_a(a_reg[s == 1 ? 1 : s-1], cfg.n0);
            end
        end
    end

    // divide the quotient by the j size
    for (genvar s = 1; s <= D; s++)
    begin : g_div_b
        always_ff @(posedge clk)
        begin
            if (fadv)
            begin
                if (s == 1)
                begin
                    b_reg[s] <= step_b(a_reg[W2][W2-1:0], cfg.n1);
                    i_reg[s] <= a_reg[W2][W3-1:W2];
                end
                else
                begin
                    b_reg[s] <= step_b(b_reg[s == 1 ? 1 : s-1], cfg.n1);
                    i_reg[s] <= i_reg[s == 1 ? 1 : s-1];
                end
            end
        end
    end

    // pack the item and flag an index past the grid
    always_ff @(posedge clk)
    begin
        if (fadv)
        begin
            item_reg.i   <= i_reg[D];
            item_reg.j   <= b_reg[D][W2-1:D];
            item_reg.k   <= b_reg[D][D-1:0];
            item_reg.oor <= (idx_reg[W3] >= count_reg);
        end
    end

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fv_reg[W3+1] && fifo_full) |=> (fv_reg[W3+1] && $stable(item_reg)))
        else $error("front dropped a waiting item");

endmodule

// ===== rtl/ssg_fifo.sv =====
module ssg_fifo
    import ssg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ssg_item_t wr_item,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output ssg_item_t rd_item
);

    localparam int PW = $clog2(FIFO_DEPTH);

    ssg_item_t     mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign full    = (cnt_reg == (PW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    // store the item
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");

endmodule

// ===== rtl/ssg_lerp.sv =====
module ssg_lerp
    import ssg_pkg::*;
(
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [VAL_W-1:0] lo,
    input  logic signed [VAL_W-1:0] hi,
    input  logic [DIM_BITS-1:0]     size,
    input  logic [DIM_BITS-1:0]     idx,
    output logic signed [VAL_W-1:0] val
);

    localparam int D  = DIM_BITS;
    localparam int DW = DIM_BITS + 1;
    localparam int QW = QUOT_W;
    localparam int WW = DW + QUOT_W;
    localparam int PW = VAL_W + DIM_BITS + 1;
    localparam int MW = QUOT_W + DIM_BITS;

    logic signed [VAL_W-1:0] delta;
    logic [D-1:0]            dm1;
    logic [DW-1:0]           dv2;
    logic signed [PW-1:0]    prod_reg;
    logic [PW-1:0]           mag;
    logic [WW-1:0]           w_reg   [0:QW];
    logic                    neg_reg [0:QW];
    logic [QW-1:0]           q;
    logic signed [VAL_W:0]   sum;
    logic                    one_pt;
    logic signed [VAL_W-1:0] val_reg;

    function automatic logic [WW-1:0] step(input logic [WW-1:0] w, input logic [DW-1:0] dv);
        logic [DW:0] t;
        logic        ge;
        t  = w[WW-1:QW-1];
        ge = (t >= {1'b0, dv});
        return {ge ? DW'(t - {1'b0, dv}) : t[DW-1:0], w[QW-2:0], ge};
    endfunction

    assign delta  = hi - lo;
    assign dm1    = size - 1'b1;
    assign dv2    = {dm1, 1'b0};
    assign mag    = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign q      = w_reg[QW][QW-1:0];
    assign sum    = neg_reg[QW] ? ((VAL_W+1)'(lo) - (VAL_W+1)'(q))
                                : ((VAL_W+1)'(lo) + (VAL_W+1)'(q));
    assign one_pt = (size == '0) || (size == D'(1));
    assign val    = val_reg;

    // span times position, then the rounding numerator 2|num| + d
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg   <= PW'(delta) * PW'($signed({1'b0, idx}));
            w_reg[0]   <= {mag[MW-1:0], 1'b0} + WW'(dm1);
            neg_reg[0] <= prod_reg[PW-1];
        end
    end

    // one quotient bit per stage over 2d
    for (genvar s = 1; s <= QW; s++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_reg[s]   <= step(w_reg[s-1], dv2);
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // apply sign and offset; a single-point axis sits at its minimum
    always_ff @(posedge clk)
    begin
        if (adv)
            val_reg <= one_pt ? lo : sum[VAL_W-1:0];
    end

endmodule

// ===== rtl/ssg_cordic.sv =====
module ssg_cordic
    import ssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      adv,
    input  logic signed [COORD_W-1:0] ang,
    output logic signed [COORD_W-1:0] cos_out,
    output logic signed [COORD_W-1:0] sin_out
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int ZW = COORD_W + SH + 2;
    localparam int XW = 34;
    localparam int N  = CORDIC_STAGES;

    localparam logic signed [ZW-1:0] PI_Z     = ZW'(Q30_PI);
    localparam logic signed [ZW-1:0] TWO_PI_Z = ZW'(Q30_TWO_PI);
    localparam logic signed [XW-1:0] PI_X     = XW'(Q30_PI);
    localparam logic signed [XW-1:0] HALF_X   = XW'(Q30_HALF_PI);
    localparam logic signed [XW-1:0] GAIN_X   = XW'(CORDIC_GAIN);

    logic signed [ZW-1:0]      z0;
    logic signed [ZW-1:0]      z_red;
    logic signed [XW-1:0]      zr_reg;
    logic signed [XW-1:0]      cx_reg [0:N];
    logic signed [XW-1:0]      cy_reg [0:N];
    logic signed [XW-1:0]      cz_reg [0:N];
    logic                      cf_reg [0:N];
    logic signed [COORD_W-1:0] cos_reg;
    logic signed [COORD_W-1:0] sin_reg;

    assign z0 = ZW'(ang) <<< SH;
    assign z_red = (z0 >= PI_Z) ? (z0 - TWO_PI_Z) : ((z0 < -PI_Z) ? (z0 + TWO_PI_Z) : z0);

    // reduce to [-pi, pi), then fold into [-pi/2, pi/2] with a half turn
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zr_reg    <= XW'(z_red);
            cx_reg[0] <= GAIN_X;
            cy_reg[0] <= '0;
            if (zr_reg > HALF_X)
            begin
                cz_reg[0] <= zr_reg - PI_X;
                cf_reg[0] <= 1'b1;
            end
            else if (zr_reg < -HALF_X)
            begin
                cz_reg[0] <= zr_reg + PI_X;
                cf_reg[0] <= 1'b1;
            end
            else
            begin
                cz_reg[0] <= zr_reg;
                cf_reg[0] <= 1'b0;
            end
        end
    end

    // rotation stages
    for (genvar s = 0; s < N; s++)
    begin : g_rot
        localparam logic signed [XW-1:0] AT = XW'(ATAN_Q30[s]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cz_reg[s] >= 0)
                begin
                    cx_reg[s+1] <= cx_reg[s] - (cy_reg[s] >>> s);
                    cy_reg[s+1] <= cy_reg[s] + (cx_reg[s] >>> s);
                    cz_reg[s+1] <= cz_reg[s] - AT;
                end
                else
                begin
                    cx_reg[s+1] <= cx_reg[s] + (cy_reg[s] >>> s);
                    cy_reg[s+1] <= cy_reg[s] - (cx_reg[s] >>> s);
                    cz_reg[s+1] <= cz_reg[s] + AT;
                end
                cf_reg[s+1] <= cf_reg[s];
            end
        end
    end

    // undo the half turn
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg <= cf_reg[N] ? COORD_W'(-cx_reg[N]) : COORD_W'(cx_reg[N]);
            sin_reg <= cf_reg[N] ? COORD_W'(-cy_reg[N]) : COORD_W'(cy_reg[N]);
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

// ===== rtl/ssg_back.sv =====
module ssg_back
    import ssg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssg_cfg_t                  cfg,
    input  logic                      fifo_empty,
    input  ssg_item_t                 rd_item,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] x_coord,
    output logic signed [COORD_W-1:0] y_coord,
    output logic signed [COORD_W-1:0] z_coord,
    output logic                      out_of_range
);

    localparam int L = BACK_LAT;
    localparam logic signed [35:0] SMAX = 36'sd2147483647;
    localparam logic signed [35:0] SMIN = -36'sd2147483648;
    localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [63:0] RND64 = 64'sd536870912;
    localparam logic signed [65:0] RND66 = 66'sd536870912;

    logic                      adv;
    logic                      bv_reg [1:L-1];
    logic                      bo_reg [1:L-1];
    logic                      ov_reg;
    logic signed [VAL_W-1:0]   theta_val;
    logic signed [VAL_W-1:0]   phi_val;
    logic signed [VAL_W-1:0]   r_val;
    logic signed [COORD_W-1:0] ct;
    logic signed [COORD_W-1:0] st;
    logic signed [COORD_W-1:0] cp;
    logic signed [COORD_W-1:0] sp;
    logic signed [31:0]        rd_reg [1:CORDIC_LAT];
    logic signed [63:0]        px_reg;
    logic signed [63:0]        py_reg;
    logic signed [63:0]        pz_reg;
    logic signed [31:0]        sp1_reg;
    logic signed [31:0]        sp2_reg;
    logic signed [63:0]        px_rnd;
    logic signed [63:0]        py_rnd;
    logic signed [63:0]        pz_rnd;
    logic signed [33:0]        rx_reg;
    logic signed [33:0]        ry_reg;
    logic signed [33:0]        zr_reg;
    logic signed [65:0]        qx_reg;
    logic signed [65:0]        qy_reg;
    logic signed [33:0]        zq_reg;
    logic signed [65:0]        qx_rnd;
    logic signed [65:0]        qy_rnd;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] z_reg;
    logic                      oor_reg;

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > SMAX)
            return 32'h7fffffff;
        else if (v < SMIN)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

    // the whole back end moves unless a finished item waits
    assign adv = !(ov_reg && out_stall);
    assign pop = adv && !fifo_empty;

    // valid and range flag ride alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s < L; s++)
                bv_reg[s] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            bv_reg[1] <= pop;
            for (int s = 2; s < L; s++)
                bv_reg[s] <= bv_reg[s-1];
            ov_reg <= bv_reg[L-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bo_reg[1] <= rd_item.oor;
            for (int s = 2; s < L; s++)
                bo_reg[s] <= bo_reg[s-1];
        end
    end

    // per-axis interpolation
    ssg_lerp u_lerp_theta (
        .clk  (clk),
        .adv  (adv),
        .lo   (VAL_W'(cfg.min_theta)),
        .hi   (VAL_W'(cfg.max_theta)),
        .size (cfg.n0),
        .idx  (rd_item.i),
        .val  (theta_val)
    );

    ssg_lerp u_lerp_phi (
        .clk  (clk),
        .adv  (adv),
        .lo   (VAL_W'(cfg.min_phi)),
        .hi   (VAL_W'(cfg.max_phi)),
        .size (cfg.n1),
        .idx  (rd_item.j),
        .val  (phi_val)
    );

    ssg_lerp u_lerp_r (
        .clk  (clk),
        .adv  (adv),
        .lo   ($signed({2'b00, cfg.min_radius})),
        .hi   ($signed({2'b00, cfg.max_radius})),
        .size (cfg.n2),
        .idx  (rd_item.k),
        .val  (r_val)
    );

    // sine and cosine of both angles
    ssg_cordic u_cordic_theta (
        .clk     (clk),
        .adv     (adv),
        .ang     (theta_val[COORD_W-1:0]),
        .cos_out (ct),
        .sin_out (st)
    );

    ssg_cordic u_cordic_phi (
        .clk     (clk),
        .adv     (adv),
        .ang     (phi_val[COORD_W-1:0]),
        .cos_out (cp),
        .sin_out (sp)
    );

    // delay the radius past the rotators
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg[1] <= r_val[31:0];
            for (int s = 2; s <= CORDIC_LAT; s++)
                rd_reg[s] <= rd_reg[s-1];
        end
    end

    assign px_rnd = px_reg + RND64;
    assign py_rnd = py_reg + RND64;
    assign pz_rnd = pz_reg + RND64;
    assign qx_rnd = qx_reg + RND66;
    assign qy_rnd = qy_reg + RND66;

    // scale by radius, round, scale x and y by sin(phi), round and saturate; out-of-range items get full scale
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg  <= 64'(rd_reg[CORDIC_LAT]) * 64'(ct);
            py_reg  <= 64'(rd_reg[CORDIC_LAT]) * 64'(st);
            pz_reg  <= 64'(rd_reg[CORDIC_LAT]) * 64'(cp);
            sp1_reg <= sp;

            rx_reg  <= px_rnd[63:30];
            ry_reg  <= py_rnd[63:30];
            zr_reg  <= pz_rnd[63:30];
            sp2_reg <= sp1_reg;

            qx_reg  <= 66'(rx_reg) * 66'(sp2_reg);
            qy_reg  <= 66'(ry_reg) * 66'(sp2_reg);
            zq_reg  <= zr_reg;

            if (bo_reg[L-1])
            begin
                x_reg <= SAT_POS;
                y_reg <= SAT_POS;
                z_reg <= SAT_POS;
            end
            else
            begin
                x_reg <= sat32(qx_rnd[65:30]);
                y_reg <= sat32(qy_rnd[65:30]);
                z_reg <= sat32(36'(zq_reg));
            end
            oor_reg <= bo_reg[L-1];
        end
    end

    assign out_valid    = ov_reg;
    assign x_coord      = x_reg;
    assign y_coord      = y_reg;
    assign z_coord      = z_reg;
    assign out_of_range = oor_reg;

    a_oor_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oor_reg) |-> (x_reg == SAT_POS && y_reg == SAT_POS && z_reg == SAT_POS))
        else $error("out-of-range point not saturated");

endmodule
